@@ sv/rectangle_test_pattern_generator_assert.svh @@
// Assertion macros for the rectangle test pattern generator.
`ifndef RECTANGLE_TEST_PATTERN_GENERATOR_ASSERT_SVH
`define RECTANGLE_TEST_PATTERN_GENERATOR_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication, checked on every clk edge outside reset
`define RTPG_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define RTPG_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define RTPG_ASSERT_IMPL(label, ante, cons, msg)
`define RTPG_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

@@ sv/rtpg_pkg.sv @@
// Shared types, constants and color helpers of the rectangle test pattern generator.
package rtpg_pkg;

    localparam int COORD_BITS_DEF = 12;
    localparam int PIX_W          = 12;
    localparam int COLOR_W        = 32;
    localparam int SCREEN_W       = 13;
    localparam int GRID_W         = 8;
    localparam int STEP_W         = 8;
    localparam int PBITS_W        = 6;
    localparam int LAYOUT_W       = 48;
    localparam int CFG_IDX_W      = 4;
    localparam int CFG_DATA_W     = 48;

    localparam int SCREEN_W_RST   = 1024;
    localparam int SCREEN_H_RST   = 768;
    localparam int GRID_SIZE_RST  = 1;
    localparam int STEP_RST       = 1;
    localparam int PBITS_RST      = 8;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SCREEN_WIDTH  = 4'd0,
        REG_SCREEN_HEIGHT = 4'd1,
        REG_GRID_SIZE     = 4'd2,
        REG_FIRST_COLOR   = 4'd3,
        REG_COLOR_STEP    = 4'd4,
        REG_INDEXED_MODE  = 4'd5,
        REG_PIXEL_BITS    = 4'd6,
        REG_COLOR_LAYOUT  = 4'd7
    } reg_idx_t;

    // controller -> datapath commands
    typedef struct packed {
        logic accept;
        logic cfg_we;
        logic div_start;
        logic div_load;
        logic mul1;
        logic mul2;
        logic load_out;
    } rtpg_cmd_t;

    // datapath -> controller status
    typedef struct packed {
        logic div_busy;
        logic div_done;
    } rtpg_stat_t;

    // One RGB component: start from first_color, advance, wrap, place.
    function automatic logic [COLOR_W-1:0] comp_field(
        input logic [COLOR_W-1:0] first,
        input logic [7:0]         size,
        input logic [7:0]         pos,
        input logic [16:0]        adv
    );
        logic [COLOR_W-1:0] m;
        logic [COLOR_W-1:0] start;
        logic [COLOR_W-1:0] v;
        m     = (size >= 8'd32) ? '1 : ((32'd1 << size[4:0]) - 32'd1);
        start = (first >> pos[4:0]) & m;
        v     = (start + COLOR_W'(adv)) & m;
        return (pos >= 8'd32) ? '0 : (v << pos[4:0]);
    endfunction

    // Low mask for indexed color depth; 32 and above keep all bits.
    function automatic logic [COLOR_W-1:0] depth_mask(input logic [PBITS_W-1:0] pb);
        return (pb >= 6'd32) ? '1 : ((32'd1 << pb[4:0]) - 32'd1);
    endfunction

endpackage

@@ sv/rtpg_div.sv @@
// Two-lane restoring divider for the cell sizes, one quotient bit per cycle.
module rtpg_div #(
    parameter int DW = rtpg_pkg::COORD_BITS_DEF + 1
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [DW-1:0] dividend_a,
    input  logic [DW-1:0] dividend_b,
    input  logic [7:0]    divisor,
    output logic          busy,
    output logic          done,
    output logic [DW-1:0] quot_a,
    output logic [DW-1:0] quot_b
);
    import rtpg_pkg::*;

    localparam int CNT_W = $clog2(DW + 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [DW-1:0]    qa_reg, qa_next, qb_reg, qb_next;
    logic [7:0]       ra_reg, ra_next, rb_reg, rb_next;
    logic [7:0]       div_reg;
    logic [8:0]       sh_a, sh_b;
    logic             ge_a, ge_b;

    always_comb
    begin
        sh_a      = {ra_reg, qa_reg[DW-1]};
        sh_b      = {rb_reg, qb_reg[DW-1]};
        ge_a      = sh_a >= {1'b0, div_reg};
        ge_b      = sh_b >= {1'b0, div_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        qa_next   = qa_reg;
        qb_next   = qb_reg;
        ra_next   = ra_reg;
        rb_next   = rb_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(DW);
            qa_next   = dividend_a;
            qb_next   = dividend_b;
            ra_next   = '0;
            rb_next   = '0;
        end
        else if (busy_reg)
        begin
            ra_next  = ge_a ? 8'(sh_a - {1'b0, div_reg}) : sh_a[7:0];
            rb_next  = ge_b ? 8'(sh_b - {1'b0, div_reg}) : sh_b[7:0];
            qa_next  = {qa_reg[DW-2:0], ge_a};
            qb_next  = {qb_reg[DW-2:0], ge_b};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
            div_reg <= divisor;
        qa_reg <= qa_next;
        qb_reg <= qb_next;
        ra_reg <= ra_next;
        rb_reg <= rb_next;
    end

    assign busy   = busy_reg;
    assign done   = done_reg;
    assign quot_a = qa_reg;
    assign quot_b = qb_reg;

endmodule

@@ sv/rtpg_ctrl.sv @@
// Controller FSM: handshakes, item sequencing and cell size recompute.
module rtpg_ctrl (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    output logic                             out_valid,
    input  logic                             out_stall,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [rtpg_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  rtpg_pkg::rtpg_stat_t             stat,
    output rtpg_pkg::rtpg_cmd_t              cmd
);
    import rtpg_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_MUL1   = 6'b000010,
        S_MUL2   = 6'b000100,
        S_LOAD   = 6'b001000,
        S_DIV    = 6'b010000,
        S_DSTART = 6'b100000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   geom;

    always_comb
    begin
        unique case (cfg_index) inside
            REG_SCREEN_WIDTH, REG_SCREEN_HEIGHT, REG_GRID_SIZE: geom = 1'b1;
            default: geom = 1'b0;
        endcase
    end

    always_comb
    begin
        cmd            = '0;
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (cfg_valid)
                begin
                    cmd.cfg_we = 1'b1;
                    if (geom)
                        state_next = S_DSTART;
                end
                else if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = S_MUL1;
                end
            end
            S_DSTART:
            begin
                // new geometry is in the registers now
                cmd.div_start = 1'b1;
                state_next    = S_DIV;
            end
            S_DIV:
            begin
                if (stat.div_done)
                begin
                    cmd.div_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            S_MUL1:
            begin
                cmd.mul1   = 1'b1;
                state_next = S_MUL2;
            end
            S_MUL2:
            begin
                cmd.mul2   = 1'b1;
                state_next = S_LOAD;
            end
            S_LOAD:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // config has priority over a pixel request in the same cycle
    assign cfg_ready = (state_reg == S_IDLE);
    assign in_stall  = (state_reg != S_IDLE) || cfg_valid;
    assign out_valid = out_valid_reg;

endmodule

@@ sv/rtpg_dp.sv @@
// Datapath: config registers, raster counters, color pipeline, output register.
module rtpg_dp #(
    parameter int COORD_BITS = rtpg_pkg::COORD_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  rtpg_pkg::rtpg_cmd_t               cmd,
    output rtpg_pkg::rtpg_stat_t              stat,
    input  logic                              restart,
    input  logic [rtpg_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [rtpg_pkg::CFG_DATA_W-1:0]   cfg_data,
    output logic [rtpg_pkg::PIX_W-1:0]        pixel_x,
    output logic [rtpg_pkg::PIX_W-1:0]        pixel_y,
    output logic [rtpg_pkg::COLOR_W-1:0]      pixel_color,
    output logic                              inside_grid,
    output logic                              frame_end
);
    import rtpg_pkg::*;

    localparam int CB    = COORD_BITS;
    localparam int DW    = CB + 1;
    localparam int CMPW  = (DW > SCREEN_W) ? DW : SCREEN_W;
    localparam logic [CMPW-1:0] DIM_TOP = CMPW'(1) << CB;
    localparam int CW_RST_I = ((SCREEN_W_RST > 2**CB) ? 2**CB : SCREEN_W_RST) / GRID_SIZE_RST;
    localparam int CH_RST_I = ((SCREEN_H_RST > 2**CB) ? 2**CB : SCREEN_H_RST) / GRID_SIZE_RST;

    // configuration
    logic [SCREEN_W-1:0] scr_w_reg, scr_h_reg;
    logic [GRID_W-1:0]   grid_reg;
    logic [COLOR_W-1:0]  first_reg;
    logic [STEP_W-1:0]   step_reg;
    logic                indexed_reg;
    logic [PBITS_W-1:0]  pbits_reg;
    logic [LAYOUT_W-1:0] layout_reg;

    // scan state
    logic [CB-1:0]     scan_x_reg, scan_x_next, scan_y_reg, scan_y_next;
    logic [CB-1:0]     offx_reg, offx_next, offy_reg, offy_next;
    logic [GRID_W-1:0] col_reg, col_next, row_reg, row_next;
    logic [DW-1:0]     cell_w_reg, cell_h_reg;

    // current item view
    logic [CB-1:0]     cur_x, cur_y, cur_offx, cur_offy;
    logic [GRID_W-1:0] cur_col, cur_row;
    logic [DW-1:0]     w_dim, h_dim, offx_inc, offy_inc;
    logic              x_last, y_last, cur_inside;

    // pipeline
    logic [PIX_W-1:0]   cap_x_reg, cap_y_reg;
    logic [GRID_W-1:0]  cap_col_reg, cap_row_reg;
    logic               cap_inside_reg, cap_end_reg;
    logic [15:0]        rn_reg, cs_reg, rs_reg;
    logic [23:0]        idx_reg;
    logic [16:0]        csr_reg;
    logic [COLOR_W-1:0] color;

    // output register
    logic [PIX_W-1:0]   px_reg, py_reg;
    logic [COLOR_W-1:0] pc_reg;
    logic               pin_reg, pend_reg;

    logic [DW-1:0] quot_w, quot_h;

    function automatic logic [DW-1:0] clamp_dim(input logic [SCREEN_W-1:0] v);
        logic [CMPW-1:0] e;
        e = CMPW'(v);
        if (e == '0)
            return DW'(1);
        else if (e > DIM_TOP)
            return DW'(DIM_TOP);
        else
            return DW'(e);
    endfunction

    assign w_dim = clamp_dim(scr_w_reg);
    assign h_dim = clamp_dim(scr_h_reg);

    rtpg_div #(
        .DW(DW)
    ) u_div (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (cmd.div_start),
        .dividend_a (w_dim),
        .dividend_b (h_dim),
        .divisor    (grid_reg),
        .busy       (stat.div_busy),
        .done       (stat.div_done),
        .quot_a     (quot_w),
        .quot_b     (quot_h)
    );

    // next pixel of the raster; restart folds in before the step
    always_comb
    begin
        cur_x    = restart ? '0 : scan_x_reg;
        cur_y    = restart ? '0 : scan_y_reg;
        cur_offx = restart ? '0 : offx_reg;
        cur_offy = restart ? '0 : offy_reg;
        cur_col  = restart ? '0 : col_reg;
        cur_row  = restart ? '0 : row_reg;

        x_last   = (DW'(cur_x) + DW'(1)) >= w_dim;
        y_last   = (DW'(cur_y) + DW'(1)) >= h_dim;
        offx_inc = DW'(cur_offx) + DW'(1);
        offy_inc = DW'(cur_offy) + DW'(1);
        cur_inside = (grid_reg != '0) && (cell_w_reg != '0) && (cell_h_reg != '0) &&
                     (cur_col < grid_reg) && (cur_row < grid_reg);

        scan_x_next = cur_x;
        scan_y_next = cur_y;
        offx_next   = cur_offx;
        offy_next   = cur_offy;
        col_next    = cur_col;
        row_next    = cur_row;
        if (x_last)
        begin
            scan_x_next = '0;
            offx_next   = '0;
            col_next    = '0;
            if (y_last)
            begin
                scan_y_next = '0;
                offy_next   = '0;
                row_next    = '0;
            end
            else
            begin
                scan_y_next = cur_y + CB'(1);
                if ((cell_h_reg != '0) && (offy_inc >= cell_h_reg))
                begin
                    offy_next = '0;
                    if (cur_row < grid_reg)
                        row_next = cur_row + GRID_W'(1);
                end
                else
                    offy_next = CB'(offy_inc);
            end
        end
        else
        begin
            scan_x_next = cur_x + CB'(1);
            if ((cell_w_reg != '0) && (offx_inc >= cell_w_reg))
            begin
                offx_next = '0;
                if (cur_col < grid_reg)
                    col_next = cur_col + GRID_W'(1);
            end
            else
                offx_next = CB'(offx_inc);
        end
    end

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scr_w_reg   <= SCREEN_W'(SCREEN_W_RST);
            scr_h_reg   <= SCREEN_W'(SCREEN_H_RST);
            grid_reg    <= GRID_W'(GRID_SIZE_RST);
            first_reg   <= '0;
            step_reg    <= STEP_W'(STEP_RST);
            indexed_reg <= 1'b1;
            pbits_reg   <= PBITS_W'(PBITS_RST);
            layout_reg  <= '0;
        end
        else if (cmd.cfg_we)
        begin
            unique case (cfg_index)
                REG_SCREEN_WIDTH:  scr_w_reg   <= cfg_data[SCREEN_W-1:0];
                REG_SCREEN_HEIGHT: scr_h_reg   <= cfg_data[SCREEN_W-1:0];
                REG_GRID_SIZE:     grid_reg    <= cfg_data[GRID_W-1:0];
                REG_FIRST_COLOR:   first_reg   <= cfg_data[COLOR_W-1:0];
                REG_COLOR_STEP:    step_reg    <= cfg_data[STEP_W-1:0];
                REG_INDEXED_MODE:  indexed_reg <= cfg_data[0];
                REG_PIXEL_BITS:    pbits_reg   <= cfg_data[PBITS_W-1:0];
                REG_COLOR_LAYOUT:  layout_reg  <= cfg_data[LAYOUT_W-1:0];
                default:           ;
            endcase
        end
    end

    // scan state and cell sizes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_x_reg <= '0;
            scan_y_reg <= '0;
            offx_reg   <= '0;
            offy_reg   <= '0;
            col_reg    <= '0;
            row_reg    <= '0;
            cell_w_reg <= DW'(CW_RST_I);
            cell_h_reg <= DW'(CH_RST_I);
        end
        else
        begin
            if (cmd.div_start)
            begin
                scan_x_reg <= '0;
                scan_y_reg <= '0;
                offx_reg   <= '0;
                offy_reg   <= '0;
                col_reg    <= '0;
                row_reg    <= '0;
            end
            else if (cmd.accept)
            begin
                scan_x_reg <= scan_x_next;
                scan_y_reg <= scan_y_next;
                offx_reg   <= offx_next;
                offy_reg   <= offy_next;
                col_reg    <= col_next;
                row_reg    <= row_next;
            end
            if (cmd.div_load)
            begin
                cell_w_reg <= (grid_reg == '0) ? '0 : quot_w;
                cell_h_reg <= (grid_reg == '0) ? '0 : quot_h;
            end
        end
    end

    // color pipeline: capture, products, index product
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            cap_x_reg      <= PIX_W'(cur_x);
            cap_y_reg      <= PIX_W'(cur_y);
            cap_col_reg    <= cur_col;
            cap_row_reg    <= cur_row;
            cap_inside_reg <= cur_inside;
            cap_end_reg    <= x_last && y_last;
        end
        if (cmd.mul1)
        begin
            rn_reg <= 16'(cap_row_reg) * 16'(grid_reg);
            cs_reg <= 16'(cap_col_reg) * 16'(step_reg);
            rs_reg <= 16'(cap_row_reg) * 16'(step_reg);
        end
        if (cmd.mul2)
        begin
            idx_reg <= 24'(rn_reg + 16'(cap_col_reg)) * 24'(step_reg);
            csr_reg <= 17'(cs_reg) + 17'(rs_reg);
        end
        if (cmd.load_out)
        begin
            px_reg   <= cap_x_reg;
            py_reg   <= cap_y_reg;
            pc_reg   <= color;
            pin_reg  <= cap_inside_reg;
            pend_reg <= cap_end_reg;
        end
    end

    always_comb
    begin
        if (!cap_inside_reg)
            color = '0;
        else if (indexed_reg)
            color = (first_reg + COLOR_W'(idx_reg)) & depth_mask(pbits_reg);
        else
            color = comp_field(first_reg, layout_reg[7:0],   layout_reg[15:8],
                               17'(cs_reg)) |
                    comp_field(first_reg, layout_reg[23:16], layout_reg[31:24],
                               17'(rs_reg)) |
                    comp_field(first_reg, layout_reg[39:32], layout_reg[47:40],
                               csr_reg);
    end

    assign pixel_x     = px_reg;
    assign pixel_y     = py_reg;
    assign pixel_color = pc_reg;
    assign inside_grid = pin_reg;
    assign frame_end   = pend_reg;

endmodule

@@ sv/rectangle_test_pattern_generator.sv @@
// Top level of the rectangle test pattern generator: controller, datapath, checks.
//
// Usage:
//  - Input channel (in_valid/in_stall, payload restart): each transaction asks
//    for one pixel; restart=1 begins the raster again at (0,0).
//  - Output channel (out_valid/out_stall): one transaction per input
//    transaction carrying pixel_x, pixel_y, pixel_color, inside_grid, frame_end.
//  - Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data): register writes.
//    Indexes beyond the register list are accepted and ignored.
//  - Pipeline: the capture, two multiply stages and the output load of the color
//    pipeline in the FSM lie between the input transaction and the result; no
//    new pixel is taken until the result register has been loaded.
//  - Writing screen width, height or grid size restarts the scan and runs the
//    shared serial divider for the cell sizes, with cfg_ready and the input
//    channel stalled until it is done.
//  - Reset: registers take their defaults (1024x768, one cell, indexed 8 bpp),
//    the scan sits at (0,0) and no result is pending.
//  - Output stall: the result register holds; the next input is taken and
//    computed meanwhile, then waits until the register frees up.
module rectangle_test_pattern_generator #(
    parameter int COORD_BITS = rtpg_pkg::COORD_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic                              restart,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [rtpg_pkg::PIX_W-1:0]        pixel_x,
    output logic [rtpg_pkg::PIX_W-1:0]        pixel_y,
    output logic [rtpg_pkg::COLOR_W-1:0]      pixel_color,
    output logic                              inside_grid,
    output logic                              frame_end,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [rtpg_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [rtpg_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import rtpg_pkg::*;
`include "rectangle_test_pattern_generator_assert.svh"

    rtpg_cmd_t  cmd;
    rtpg_stat_t stat;

    // sequencing, handshakes, divider control
    rtpg_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .stat      (stat),
        .cmd       (cmd)
    );

    // registers, raster counters, color math and result register
    rtpg_dp #(
        .COORD_BITS(COORD_BITS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .restart     (restart),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .pixel_x     (pixel_x),
        .pixel_y     (pixel_y),
        .pixel_color (pixel_color),
        .inside_grid (inside_grid),
        .frame_end   (frame_end)
    );

    // config and pixel transactions never complete on the same edge
    `RTPG_ASSERT_IMPL(a_cfg_pix_excl, cfg_valid && cfg_ready, in_stall, "config and pixel transaction overlap")
    // no pixel is taken while the cell sizes are being recomputed
    `RTPG_ASSERT_IMPL(a_div_blocks_in, stat.div_busy, in_stall && !cfg_ready, "transaction taken during divide")
    // result register is only overwritten once it is free
    `RTPG_ASSERT_IMPL(a_load_free, cmd.load_out, !out_valid || !out_stall, "result overwritten while stalled")
    // an accepted pixel always moves into the multiply stage
    `RTPG_ASSERT_NEXT(a_accept_mul, cmd.accept, cmd.mul1, "accepted pixel not sequenced")

endmodule

@@ tb/sv/rectangle_test_pattern_generator_tb.sv @@
// Self-checking testbench of the rectangle test pattern generator.
module rectangle_test_pattern_generator_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import rtpg_pkg::*;

    // ------------------------------------------------------------------
    // Run sizing
    // ------------------------------------------------------------------
    localparam int          RANDOM_ITEMS     = 950;
    localparam int          DRAIN_CYCLES     = 16;   // idle clocks after the last pixel is returned
    localparam int          REG_COUNT        = 8;
    localparam logic [3:0]  FIRST_UNUSED_REG = 4'd8; // 8..15 are accepted and dropped
    localparam int          REG_BITS [REG_COUNT] = '{13, 13, 8, 32, 8, 1, 6, 48};

    // One produced pixel, as carried on the output channel.
    typedef struct packed {
        logic [11:0] x;
        logic [11:0] y;
        logic [31:0] color;
        logic        in_grid;
        logic        fend;
    } pixel_t;

    typedef enum logic {ROW_WRITE, ROW_PIXEL} row_kind_t;

    // Directed plan: register writes and pixel requests. A pixel row with
    // typed=1 carries its expected pixel; otherwise the predictor decides.
    typedef struct packed {
        row_kind_t   kind;
        logic [3:0]  reg_sel;
        logic [47:0] value;
        logic        restart;
        logic        typed;
        pixel_t      want;
    } plan_row_t;

    localparam int PLAN_LEN = 39;

    // ------------------------------------------------------------------
    // Clock, reset and DUT ports; every input starts at a known value
    // ------------------------------------------------------------------
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic                  in_valid  = 1'b0;
    logic                  restart   = 1'b0;
    logic                  out_stall = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    logic                  in_stall;
    logic                  out_valid;
    logic [PIX_W-1:0]      pixel_x;
    logic [PIX_W-1:0]      pixel_y;
    logic [COLOR_W-1:0]    pixel_color;
    logic                  inside_grid;
    logic                  frame_end;
    logic                  cfg_ready;

    always #4 clk = ~clk;

    rectangle_test_pattern_generator uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .restart     (restart),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .pixel_x     (pixel_x),
        .pixel_y     (pixel_y),
        .pixel_color (pixel_color),
        .inside_grid (inside_grid),
        .frame_end   (frame_end),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    // ------------------------------------------------------------------
    // Predictor: shadow registers and raster state
    // ------------------------------------------------------------------
    bit [12:0] set_width, set_height;
    bit [7:0]  set_grid;
    bit [31:0] set_first;
    bit [7:0]  set_step;
    bit        set_indexed;
    bit [5:0]  set_pbits;
    bit [47:0] set_layout;

    bit [12:0] gen_x, gen_y;     // next pixel of the raster
    bit [12:0] ofs_x, ofs_y;     // position inside the current rectangle
    bit [7:0]  blk_col, blk_row; // rectangle index, stops at grid size (outside strip)
    bit [12:0] blk_w, blk_h;     // rectangle size, up to 4096

    pixel_t pending_pixels [$];  // expected pixels, oldest first
    int     mismatches = 0;

    bit tx_idle_on = 1'b1;
    bit rx_idle_on = 1'b1;

    // 0 counts as 1, anything past 4096 counts as 4096
    function automatic bit [12:0] clamp_screen(input bit [12:0] v);
        if (v == 13'd0)
            return 13'd1;
        if (v > 13'd4096)
            return 13'd4096;
        return v;
    endfunction

    // Cell sizes follow the geometry; the raster goes back to the top-left corner.
    function automatic void rescan();
        if (set_grid != 8'd0) begin
            blk_w = clamp_screen(set_width) / {5'd0, set_grid};
            blk_h = clamp_screen(set_height) / {5'd0, set_grid};
        end else begin
            blk_w = '0;
            blk_h = '0;
        end
        gen_x   = '0;
        gen_y   = '0;
        ofs_x   = '0;
        ofs_y   = '0;
        blk_col = '0;
        blk_row = '0;
    endfunction

    function automatic void reset_predictor();
        set_width   = 13'(SCREEN_W_RST);
        set_height  = 13'(SCREEN_H_RST);
        set_grid    = 8'(GRID_SIZE_RST);
        set_first   = '0;
        set_step    = 8'(STEP_RST);
        set_indexed = 1'b1;
        set_pbits   = 6'(PBITS_RST);
        set_layout  = '0;
        rescan();
    endfunction

    // One RGB channel: start from the first color, advance, wrap at its size,
    // place at its position. Size 32+ keeps all bits, position 32+ drops it.
    function automatic bit [63:0] channel_value(input bit [7:0] size, input bit [7:0] pos,
                                                input bit [63:0] adv);
        bit [63:0] m;
        bit [63:0] start;
        bit [63:0] v;
        if (size >= 8'd32)
            m = 64'hFFFF_FFFF;
        else
            m = (64'd1 << size) - 64'd1;
        if (pos >= 8'd32)
            return 64'd0;
        start = (64'(set_first) >> pos) & m;
        v     = (start + adv) & m;
        return (v << pos) & 64'hFFFF_FFFF;
    endfunction

    function automatic bit [31:0] rect_color(input bit [7:0] col, input bit [7:0] row);
        bit [63:0] sum;
        bit [63:0] depth;
        bit [63:0] mix;
        bit [7:0]  rs, rp, gs, gp, bs, bp;
        if (set_indexed) begin
            sum = 64'(set_first) + (64'(row) * 64'(set_grid) + 64'(col)) * 64'(set_step);
            if (set_pbits >= 6'd32)
                depth = 64'hFFFF_FFFF;
            else
                depth = (64'd1 << set_pbits) - 64'd1;
            return sum[31:0] & depth[31:0];
        end
        {bp, bs, gp, gs, rp, rs} = set_layout;
        mix = channel_value(rs, rp, 64'(col) * 64'(set_step))
            | channel_value(gs, gp, 64'(row) * 64'(set_step))
            | channel_value(bs, bp, (64'(col) + 64'(row)) * 64'(set_step));
        return mix[31:0];
    endfunction

    // Works out the pixel for one accepted request and steps the raster.
    function automatic pixel_t next_pixel(input bit rs);
        pixel_t    px;
        bit [12:0] w, h;
        bit        in_grid;
        if (rs)
            rescan();
        w       = clamp_screen(set_width);
        h       = clamp_screen(set_height);
        in_grid = set_grid != 8'd0 && blk_w != 13'd0 && blk_h != 13'd0
                  && blk_col < set_grid && blk_row < set_grid;
        px.x       = gen_x[11:0];
        px.y       = gen_y[11:0];
        px.color   = in_grid ? rect_color(blk_col, blk_row) : 32'd0;
        px.in_grid = in_grid;
        px.fend    = (gen_x + 13'd1 >= w) && (gen_y + 13'd1 >= h);
        if (gen_x + 13'd1 >= w) begin
            // end of line: back to column 0, then next row or wrap the frame
            gen_x   = '0;
            ofs_x   = '0;
            blk_col = '0;
            if (gen_y + 13'd1 >= h) begin
                gen_y   = '0;
                ofs_y   = '0;
                blk_row = '0;
            end else begin
                gen_y = gen_y + 13'd1;
                ofs_y = ofs_y + 13'd1;
                if (blk_h != 13'd0 && ofs_y >= blk_h) begin
                    ofs_y = '0;
                    if (blk_row < set_grid)
                        blk_row = blk_row + 8'd1;
                end
            end
        end else begin
            gen_x = gen_x + 13'd1;
            ofs_x = ofs_x + 13'd1;
            if (blk_w != 13'd0 && ofs_x >= blk_w) begin
                ofs_x = '0;
                if (blk_col < set_grid)
                    blk_col = blk_col + 8'd1;
            end
        end
        return px;
    endfunction

    // Register write as seen by the block; geometry writes restart the raster.
    function automatic void apply_reg(input logic [3:0] reg_sel, input logic [47:0] value);
        case (reg_sel)
            REG_SCREEN_WIDTH:
            begin
                set_width = value[12:0];
                rescan();
            end
            REG_SCREEN_HEIGHT:
            begin
                set_height = value[12:0];
                rescan();
            end
            REG_GRID_SIZE:
            begin
                set_grid = value[7:0];
                rescan();
            end
            REG_FIRST_COLOR:  set_first   = value[31:0];
            REG_COLOR_STEP:   set_step    = value[7:0];
            REG_INDEXED_MODE: set_indexed = value[0];
            REG_PIXEL_BITS:   set_pbits   = value[5:0];
            REG_COLOR_LAYOUT: set_layout  = value;
            default:          ;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Stimulus tasks
    // ------------------------------------------------------------------

    // Writes only with the block idle: input valid low, every pixel returned.
    // cfg_valid stays high between back-to-back writes;
    // the next pixel request lowers it.
    task automatic write_reg(input logic [3:0] reg_sel, input logic [47:0] value);
        in_valid <= 1'b0;
        while (pending_pixels.size() != 0)
            @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= reg_sel;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        apply_reg(reg_sel, value);
    endtask

    // One pixel request transaction. Prediction happens at the accepting edge.
    task automatic send_pixel(input logic rs, input logic typed, input pixel_t want);
        int unsigned gap;
        cfg_valid <= 1'b0;
        gap = tx_idle_on ? $urandom_range(0, 18) : 0;
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        restart  <= rs;
        do
            @(posedge clk);
        while (in_stall);
        want = typed ? want : next_pixel(rs);
        if (typed)
            void'(next_pixel(rs));
        pending_pixels.push_back(want);
    endtask

    // Mostly tiny screens so frames wrap often; now and then the extremes.
    function automatic logic [47:0] pick_dim(input int unsigned usual_max);
        case ($urandom_range(0, 9))
            0:       return 48'd0;
            1:       return 48'd4096;
            2:       return 48'($urandom_range(4097, 8191));
            default: return 48'($urandom_range(1, usual_max));
        endcase
    endfunction

    // New random setting: a random subset of registers in a rotated order,
    // sometimes junk above the register width, sometimes an unused index.
    task automatic random_setup();
        logic [47:0] vals [REG_COUNT];
        int unsigned lead;
        logic [3:0]  reg_sel;
        vals[REG_SCREEN_WIDTH]  = pick_dim(12);
        vals[REG_SCREEN_HEIGHT] = pick_dim(8);
        case ($urandom_range(0, 9))
            0:       vals[REG_GRID_SIZE] = 48'd0;
            1:       vals[REG_GRID_SIZE] = 48'd255;
            2:       vals[REG_GRID_SIZE] = 48'($urandom_range(0, 255));
            default: vals[REG_GRID_SIZE] = 48'($urandom_range(1, 5));
        endcase
        vals[REG_FIRST_COLOR]  = 48'($urandom);
        vals[REG_COLOR_STEP]   = 48'($urandom_range(0, 255));
        vals[REG_INDEXED_MODE] = 48'($urandom_range(0, 1));
        vals[REG_PIXEL_BITS]   = 48'($urandom_range(0, 63));
        if ($urandom_range(0, 3) == 0)
            vals[REG_COLOR_LAYOUT] = 48'({$urandom, $urandom});
        else
            // {blue pos, blue size, green pos, green size, red pos, red size}
            vals[REG_COLOR_LAYOUT] = {8'($urandom_range(0, 31)), 8'($urandom_range(0, 12)),
                                      8'($urandom_range(0, 31)), 8'($urandom_range(0, 12)),
                                      8'($urandom_range(0, 31)), 8'($urandom_range(0, 12))};
        for (int i = 0; i < REG_COUNT - 1; i++)
            if ($urandom_range(0, 7) == 0)
                vals[i] = vals[i] | 48'({$urandom, $urandom} << REG_BITS[i]);

        lead = $urandom_range(0, REG_COUNT - 1);
        for (int k = 0; k < REG_COUNT; k++) begin
            reg_sel = 4'((lead + k) % REG_COUNT);
            if (k == 0 || $urandom_range(0, 3) != 0)
                write_reg(reg_sel, vals[reg_sel]);
        end
        if ($urandom_range(0, 4) == 0)
            write_reg(FIRST_UNUSED_REG + 4'($urandom_range(0, 7)), 48'({$urandom, $urandom}));
    endtask

    // ------------------------------------------------------------------
    // Directed plan
    // ------------------------------------------------------------------
    plan_row_t plan [PLAN_LEN] = '{
        // reset defaults: 1024x768, one rectangle, color 0 everywhere
        '{ROW_PIXEL, 4'd0, 48'd0, 1'b0, 1'b1, '{12'd0, 12'd0, 32'd0, 1'b1, 1'b0}},
        '{ROW_PIXEL, 4'd0, 48'd0, 1'b0, 1'b1, '{12'd1, 12'd0, 32'd0, 1'b1, 1'b0}},
        '{ROW_PIXEL, 4'd0, 48'd0, 1'b1, 1'b1, '{12'd0, 12'd0, 32'd0, 1'b1, 1'b0}},
        '{ROW_PIXEL, 4'd0, 48'd0, 1'b0, 1'b1, '{12'd1, 12'd0, 32'd0, 1'b1, 1'b0}},
        // zero screen size acts as 1x1; zero pixel depth gives color 0
        '{ROW_WRITE, REG_SCREEN_WIDTH,  48'd0,           1'b0, 1'b0, '0},
        '{ROW_WRITE, REG_SCREEN_HEIGHT, 48'd0,           1'b0, 1'b0, '0},
        '{ROW_WRITE, REG_FIRST_COLOR,   48'hFFFF_FFFF,   1'b0, 1'b0, '0},
        '{ROW_WRITE, REG_PIXEL_BITS,    48'd0,           1'b0, 1'b0, '0},
        '{ROW_PIXEL, 4'd0, 48'd0, 1'b0, 1'b1, '{12'd0, 12'd0, 32'd0, 1'b1, 1'b1}},
        '{ROW_PIXEL, 4'd0, 48'd0, 1'b1, 1'b1, '{12'd0, 12'd0, 32'd0, 1'b1, 1'b1}},
        // depth above 32 acts as 32
        '{ROW_WRITE, REG_PIXEL_BITS,    48'd63,          1'b0, 1'b0, '0},
        '{ROW_PIXEL, 4'd0, 48'd0, 1'b0, 1'b1, '{12'd0, 12'd0, 32'hFFFF_FFFF, 1'b1, 1'b1}},
        // no grid: everything outside
        '{ROW_WRITE, REG_GRID_SIZE,     48'd0,           1'b0, 1'b0, '0},
        '{ROW_PIXEL, 4'd0, 48'd0, 1'b0, 1'b1, '{12'd0, 12'd0, 32'd0, 1'b0, 1'b1}},
        // oversize screen clamps to 4096; largest grid; unused index is dropped
        '{ROW_WRITE, REG_SCREEN_WIDTH,  48'd8191,        1'b0, 1'b0, '0},
        '{ROW_WRITE, REG_SCREEN_HEIGHT, 48'd4096,        1'b0, 1'b0, '0},
        '{ROW_WRITE, REG_GRID_SIZE,     48'd255,         1'b0, 1'b0, '0},
        '{ROW_WRITE, FIRST_UNUSED_REG,  48'hFFFF_FFFF_FFFF, 1'b0, 1'b0, '0},
        '{ROW_PIXEL, 4'd0, 48'd0, 1'b0, 1'b1, '{12'd0, 12'd0, 32'hFFFF_FFFF, 1'b1, 1'b0}},
        '{ROW_PIXEL, 4'd0, 48'd0, 1'b0, 1'b0, '0},
        // direct color: red size 40 at 0, green size 6 at 33, blue size 32 at 4
        '{ROW_WRITE, REG_INDEXED_MODE,  48'd0,           1'b0, 1'b0, '0},
        '{ROW_WRITE, REG_COLOR_STEP,    48'd255,         1'b0, 1'b0, '0},
        '{ROW_WRITE, REG_COLOR_LAYOUT,  48'h04_20_21_06_00_28, 1'b0, 1'b0, '0},
        '{ROW_WRITE, REG_FIRST_COLOR,   48'h89AB_CDEF,   1'b0, 1'b0, '0},
        '{ROW_WRITE, REG_SCREEN_WIDTH,  48'd5,           1'b0, 1'b0, '0},
        '{ROW_WRITE, REG_SCREEN_HEIGHT, 48'd2,           1'b0, 1'b0, '0},
        '{ROW_WRITE, REG_GRID_SIZE,     48'd2,           1'b0, 1'b0, '0},
        // 5x2 screen, 2x2 grid of 2x1 cells with a one-pixel strip on the right
        '{ROW_PIXEL, 4'd0, 48'd0, 1'b0, 1'b0, '0},
        '{ROW_PIXEL, 4'd0, 48'd0, 1'b0, 1'b0, '0},
        '{ROW_PIXEL, 4'd0, 48'd0, 1'b0, 1'b0, '0},
        '{ROW_PIXEL, 4'd0, 48'd0, 1'b0, 1'b0, '0},
        '{ROW_PIXEL, 4'd0, 48'd0, 1'b0, 1'b0, '0},
        '{ROW_PIXEL, 4'd0, 48'd0, 1'b0, 1'b0, '0},
        '{ROW_PIXEL, 4'd0, 48'd0, 1'b1, 1'b0, '0},
        '{ROW_PIXEL, 4'd0, 48'd0, 1'b0, 1'b0, '0},
        '{ROW_PIXEL, 4'd0, 48'd0, 1'b0, 1'b0, '0},
        '{ROW_PIXEL, 4'd0, 48'd0, 1'b0, 1'b0, '0},
        '{ROW_PIXEL, 4'd0, 48'd0, 1'b0, 1'b0, '0},
        '{ROW_PIXEL, 4'd0, 48'd0, 1'b0, 1'b0, '0}
    };

    // ------------------------------------------------------------------
    // Output side: random stall per transaction, checker
    // ------------------------------------------------------------------
    initial begin
        int unsigned hold;
        @(posedge clk);
        forever begin
            hold = rx_idle_on ? $urandom_range(0, 18) : 0;
            if (hold != 0) begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            out_stall <= 1'b0;
            do
                @(posedge clk);
            while (!(out_valid && !out_stall));
        end
    end

    task automatic check_field(input string what, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s expected 0x%0h got 0x%0h", $time, what, want, got);
            mismatches++;
        end
    endtask

    // Values read here are the ones the block saw at this edge.
    always @(posedge clk) begin
        pixel_t head;
        if (rst_n && out_valid && !out_stall) begin
            if (pending_pixels.size() == 0) begin
                $display("%0t: pixel (%0d,%0d) with no request outstanding",
                         $time, pixel_x, pixel_y);
                mismatches++;
            end else begin
                head = pending_pixels.pop_front();
                check_field("pixel_x",     32'(head.x),       32'(pixel_x));
                check_field("pixel_y",     32'(head.y),       32'(pixel_y));
                check_field("pixel_color", head.color,        pixel_color);
                check_field("inside_grid", 32'(head.in_grid), 32'(inside_grid));
                check_field("frame_end",   32'(head.fend),    32'(frame_end));
            end
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        int unsigned random_items;
        int unsigned burst;
        random_items = 0;
        reset_predictor();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i]) begin
            if (plan[i].kind == ROW_WRITE)
                write_reg(plan[i].reg_sel, plan[i].value);
            else
                send_pixel(plan[i].restart, plan[i].typed, plan[i].want);
        end

        // Random phases: new setting, then a burst of requests with rare restarts.
        while (random_items < RANDOM_ITEMS) begin
            random_setup();
            tx_idle_on = $urandom_range(0, 3) != 0;
            rx_idle_on = $urandom_range(0, 3) != 0;
            burst      = $urandom_range(20, 60);
            repeat (burst) begin
                send_pixel($urandom_range(0, 24) == 0, 1'b0, '0);
                random_items++;
            end
        end

        in_valid <= 1'b0;
        while (pending_pixels.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("rectangle_test_pattern_generator_tb: PASS");
        else
            $display("rectangle_test_pattern_generator_tb: FAIL");
        $finish;
    end

    // Watchdog: ends the run with a failure on timeout.
    initial begin
        #5_000_000;
        $display("%0t: timeout", $time);
        $display("rectangle_test_pattern_generator_tb: FAIL");
        $finish;
    end

endmodule
